[hdl/y2r_pkg.sv]
// Shared types, constants and the per-channel helper functions of the YUYV to RGB888 converter.
package y2r_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned GainW    = 9;
  localparam int unsigned ChromaW  = 9;
  localparam int unsigned ProdW    = 25;
  localparam int unsigned SumW     = 27;
  localparam int unsigned FracBits = 16;
  localparam int unsigned GainShift = 8;

  localparam logic [GainW-1:0] GainReset  = 9'd220;
  localparam logic [ByteW-1:0] ChromaMid  = 8'd128;
  localparam logic [ByteW-1:0] ChannelMax = 8'd255;

  localparam logic signed [ProdW-1:0] CoefRCr = 25'sd89831;
  localparam logic signed [ProdW-1:0] CoefGCr = 25'sd45744;
  localparam logic signed [ProdW-1:0] CoefGCb = 25'sd22127;
  localparam logic signed [ProdW-1:0] CoefBCb = 25'sd113537;

  typedef struct packed {
    logic [ByteW-1:0] luma_first;
    logic [ByteW-1:0] chroma_blue;
    logic [ByteW-1:0] luma_second;
    logic [ByteW-1:0] chroma_red;
    logic             frame_end;
  } yuyv_t;

  typedef struct packed {
    logic [ByteW-1:0] red_first;
    logic [ByteW-1:0] green_first;
    logic [ByteW-1:0] blue_first;
    logic [ByteW-1:0] red_second;
    logic [ByteW-1:0] green_second;
    logic [ByteW-1:0] blue_second;
    logic             frame_end_out;
  } rgb_pair_t;

  typedef struct packed {
    logic [ByteW-1:0]        luma_first;
    logic [ByteW-1:0]        luma_second;
    logic signed [ProdW-1:0] r_cr;
    logic signed [ProdW-1:0] g_cr;
    logic signed [ProdW-1:0] g_cb;
    logic signed [ProdW-1:0] b_cb;
    logic                    frame_end;
  } chroma_prod_t;

  function automatic logic signed [ChromaW-1:0] center_chroma(input logic [ByteW-1:0] c);
    center_chroma = $signed({1'b0, c}) - $signed({1'b0, ChromaMid});
  endfunction

  function automatic logic signed [SumW-1:0] luma_term(input logic [ByteW-1:0] y);
    luma_term = $signed({{(SumW-ByteW-FracBits){1'b0}}, y, {FracBits{1'b0}}});
  endfunction

  function automatic logic [ByteW-1:0] floor_clamp(input logic signed [SumW-1:0] sum);
    logic signed [SumW-FracBits-1:0] whole;
    whole = sum[SumW-1:FracBits];
    if (whole < 0) begin
      floor_clamp = '0;
    end else if (whole > $signed({{(SumW-FracBits-ByteW){1'b0}}, ChannelMax})) begin
      floor_clamp = ChannelMax;
    end else begin
      floor_clamp = whole[ByteW-1:0];
    end
  endfunction

  function automatic logic [ByteW-1:0] apply_gain(input logic [ByteW-1:0] ch,
                                                  input logic [GainW-1:0] gain);
    logic [ByteW+GainW-1:0] prod;
    prod = (ByteW+GainW)'(ch) * (ByteW+GainW)'(gain);
    if (prod[ByteW+GainW-1:GainShift] > {1'b0, ChannelMax}) begin
      apply_gain = ChannelMax;
    end else begin
      apply_gain = prod[GainShift+ByteW-1:GainShift];
    end
  endfunction

endpackage

[hdl/yuyv_to_rgb888_converter.sv]
// Top level of the YUYV 4:2:2 to RGB888 converter with output gain.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one YUYV word per
// transaction; output channel (out_valid_o / out_stall_i / out_data_o) carries
// the two RGB888 pixels of that word plus the frame end flag.
// A transaction completes on a rising edge with valid high and stall low.
// Throughput: one word per cycle while out_stall_i is low. Each accepted word
// passes through the three register stages (chroma products, luma add and clamp,
// gain multiply into the output register) before it reaches out_data_o with
// out_valid_o high.
// Receiver stall: each stage holds while its successor is full and stalled;
// bubbles are squeezed out, so in_stall_o rises only once all three stages hold
// data. Nothing is dropped or repeated.
// Configuration: cfg_valid_i / cfg_ready_o / cfg_data_i write the 9-bit gain;
// cfg_ready_o is always high. Write it only while the pipeline is empty.
// Reset: rst_ni clears all stage valid bits and sets the gain to 220.
module yuyv_to_rgb888_converter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  y2r_pkg::yuyv_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output y2r_pkg::rgb_pair_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [y2r_pkg::GainW-1:0]   cfg_data_i
);

  logic [y2r_pkg::GainW-1:0] gain_q;
  logic [y2r_pkg::GainW-1:0] gain_d;
  logic                      s1_valid;
  logic                      s1_stall;
  y2r_pkg::chroma_prod_t     s1_data;
  logic                      s2_valid;
  logic                      s2_stall;
  y2r_pkg::rgb_pair_t        s2_data;

  assign cfg_ready_o = 1'b1;
  assign gain_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= y2r_pkg::GainReset;
    end else begin
      gain_q <= gain_d;
    end
  end

  y2r_chroma_stage u_chroma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .valid_o (s1_valid),
    .stall_i (s1_stall),
    .data_o  (s1_data)
  );

  y2r_clamp_stage u_clamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .stall_o (s1_stall),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .stall_i (s2_stall),
    .data_o  (s2_data)
  );

  y2r_gain_stage u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .gain_i  (gain_q),
    .valid_i (s2_valid),
    .stall_o (s2_stall),
    .data_i  (s2_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid && s2_valid && out_valid_o))
    else $error("input stalled while a stage is empty");

  a_item_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted word did not reach the output");

  a_zero_gain_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid && !s2_stall && gain_q == '0) |=>
      (out_data_o.red_first == '0 && out_data_o.green_first == '0 &&
       out_data_o.blue_first == '0 && out_data_o.red_second == '0 &&
       out_data_o.green_second == '0 && out_data_o.blue_second == '0))
    else $error("nonzero channel with zero gain");

endmodule

[hdl/y2r_chroma_stage.sv]
// First pipeline stage: centers the chroma and forms the four coefficient products.
module y2r_chroma_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  y2r_pkg::yuyv_t        data_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output y2r_pkg::chroma_prod_t data_o
);

  logic                         valid_q;
  logic                         adv;
  y2r_pkg::chroma_prod_t        data_d;
  y2r_pkg::chroma_prod_t        data_q;
  logic signed [y2r_pkg::ChromaW-1:0] cb;
  logic signed [y2r_pkg::ChromaW-1:0] cr;

  assign adv     = !valid_q || !stall_i;
  assign stall_o = !adv;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    cb = y2r_pkg::center_chroma(data_i.chroma_blue);
    cr = y2r_pkg::center_chroma(data_i.chroma_red);
    data_d.luma_first  = data_i.luma_first;
    data_d.luma_second = data_i.luma_second;
    data_d.r_cr        = y2r_pkg::CoefRCr * y2r_pkg::ProdW'(cr);
    data_d.g_cr        = y2r_pkg::CoefGCr * y2r_pkg::ProdW'(cr);
    data_d.g_cb        = y2r_pkg::CoefGCb * y2r_pkg::ProdW'(cb);
    data_d.b_cb        = y2r_pkg::CoefBCb * y2r_pkg::ProdW'(cb);
    data_d.frame_end   = data_i.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

[hdl/y2r_clamp_stage.sv]
// Second pipeline stage: adds luma to the products (green subtracts them), floors and clamps all six channels.
module y2r_clamp_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  y2r_pkg::chroma_prod_t data_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output y2r_pkg::rgb_pair_t    data_o
);

  logic                      valid_q;
  logic                      adv;
  y2r_pkg::rgb_pair_t        data_d;
  y2r_pkg::rgb_pair_t        data_q;
  logic signed [y2r_pkg::SumW-1:0] y0;
  logic signed [y2r_pkg::SumW-1:0] y1;
  logic signed [y2r_pkg::SumW-1:0] r_cr;
  logic signed [y2r_pkg::SumW-1:0] g_c;
  logic signed [y2r_pkg::SumW-1:0] b_cb;

  assign adv     = !valid_q || !stall_i;
  assign stall_o = !adv;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    y0   = y2r_pkg::luma_term(data_i.luma_first);
    y1   = y2r_pkg::luma_term(data_i.luma_second);
    r_cr = y2r_pkg::SumW'(data_i.r_cr);
    g_c  = y2r_pkg::SumW'(data_i.g_cr) + y2r_pkg::SumW'(data_i.g_cb);
    b_cb = y2r_pkg::SumW'(data_i.b_cb);
    data_d.red_first     = y2r_pkg::floor_clamp(y0 + r_cr);
    data_d.green_first   = y2r_pkg::floor_clamp(y0 - g_c);
    data_d.blue_first    = y2r_pkg::floor_clamp(y0 + b_cb);
    data_d.red_second    = y2r_pkg::floor_clamp(y1 + r_cr);
    data_d.green_second  = y2r_pkg::floor_clamp(y1 - g_c);
    data_d.blue_second   = y2r_pkg::floor_clamp(y1 + b_cb);
    data_d.frame_end_out = data_i.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

[hdl/y2r_gain_stage.sv]
// Third pipeline stage and output register: scales each channel by the gain and saturates.
module y2r_gain_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [y2r_pkg::GainW-1:0]   gain_i,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  y2r_pkg::rgb_pair_t          data_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output y2r_pkg::rgb_pair_t          data_o
);

  logic               valid_q;
  logic               adv;
  y2r_pkg::rgb_pair_t data_d;
  y2r_pkg::rgb_pair_t data_q;

  assign adv     = !valid_q || !stall_i;
  assign stall_o = !adv;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d.red_first     = y2r_pkg::apply_gain(data_i.red_first, gain_i);
    data_d.green_first   = y2r_pkg::apply_gain(data_i.green_first, gain_i);
    data_d.blue_first    = y2r_pkg::apply_gain(data_i.blue_first, gain_i);
    data_d.red_second    = y2r_pkg::apply_gain(data_i.red_second, gain_i);
    data_d.green_second  = y2r_pkg::apply_gain(data_i.green_second, gain_i);
    data_d.blue_second   = y2r_pkg::apply_gain(data_i.blue_second, gain_i);
    data_d.frame_end_out = data_i.frame_end_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
